[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define HSD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define HSD_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/hsd_pkg.sv]
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types, constants and helpers of the HUB75 scan and PWM driver.
// ----------------------------------------------------------------------------
package hsd_pkg;

	// Default panel geometry
	localparam int SCAN_ADDRESSES_DEF = 16;
	localparam int PANEL_COLUMNS_DEF  = 64;
	localparam int PANEL_ROWS_DEF     = 32;

	// Field widths
	localparam int PORTRAIT_X_W = 5;
	localparam int PORTRAIT_Y_W = 6;
	localparam int PIXEL_WORD_W = 32;
	localparam int ROW_ADDR_W   = 4;
	localparam int SHIFT_COL_W  = 6;
	localparam int STEP_W       = 16;
	localparam int PCT_W        = 7;
	localparam int THR_W        = 8;
	localparam int CHAN_W       = 8;
	localparam int CFG_VALUE_W  = 16;

	localparam int PCT_DIV = 100;

	localparam logic [STEP_W-1:0]   START_STEP_RESET = 16'h1800;
	localparam logic [PCT_W-1:0]    DECAY_RESET      = 7'd91;
	localparam logic [3*CHAN_W-1:0] RESET_PIXEL      = {3{8'h50}};

	typedef logic [3*CHAN_W-1:0] pixel_t;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	typedef enum logic [0:0] {
		CFG_START_STEP    = 1'b0,
		CFG_DECAY_PERCENT = 1'b1
	} cfg_index_t;

	typedef struct packed {
		op_t                     op;
		logic [PORTRAIT_X_W-1:0] portrait_x;
		logic [PORTRAIT_Y_W-1:0] portrait_y;
		logic [PIXEL_WORD_W-1:0] pixel_word;
		logic                    swap_after;
	} in_item_t;

	typedef struct packed {
		logic                   upper_red;
		logic                   upper_green;
		logic                   upper_blue;
		logic                   lower_red;
		logic                   lower_green;
		logic                   lower_blue;
		logic [ROW_ADDR_W-1:0]  row_address;
		logic [SHIFT_COL_W-1:0] shift_column;
		logic                   latch_now;
		logic                   frame_start;
	} out_item_t;

	typedef struct packed {
		cfg_index_t             reg_index;
		logic [CFG_VALUE_W-1:0] value;
	} cfg_write_t;

	typedef struct packed {
		logic [STEP_W-1:0] start_step;
		logic [PCT_W-1:0]  decay_percent;
	} cfg_regs_t;

	typedef struct packed {
		logic frame_start;
		logic advance;
	} thr_ctl_t;

	// c * level / 255, rounded down, exact for every 16-bit product
	function automatic logic [CHAN_W-1:0] scale_channel(
		input logic [CHAN_W-1:0] c,
		input logic [CHAN_W-1:0] level
	);
		logic [2*CHAN_W-1:0] prod;
		logic [2*CHAN_W:0]   corr;
		prod = c * level;
		corr = {1'b0, prod} + (2*CHAN_W+1)'(1) + {{(CHAN_W+1){1'b0}}, prod[2*CHAN_W-1:CHAN_W]};
		return corr[2*CHAN_W-1:CHAN_W];
	endfunction

	// {red, green, blue}: on where the threshold is at or below the byte
	function automatic logic [2:0] pixel_bits(
		input logic [THR_W-1:0] thr,
		input pixel_t           px
	);
		logic [2:0] bits;
		bits[2] = (thr <= px[3*CHAN_W-1:2*CHAN_W]);
		bits[1] = (thr <= px[2*CHAN_W-1:CHAN_W]);
		bits[0] = (thr <= px[CHAN_W-1:0]);
		return bits;
	endfunction

endpackage

[hw/rtl/hsd_stream_if.sv]
// ----------------------------------------------------------------------------
// hsd_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface hsd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
	modport mon    (input valid, input data, input ready);
endinterface

[hw/rtl/hsd_frame_store.sv]
// ----------------------------------------------------------------------------
// hsd_frame_store
// Double-buffered frame memory: one write port, two registered read ports,
// and a clearing pass after reset that loads both banks.
// ----------------------------------------------------------------------------
module hsd_frame_store
	import hsd_pkg::*;
#(
	parameter int PANEL_ROWS    = PANEL_ROWS_DEF,
	parameter int PANEL_COLUMNS = PANEL_COLUMNS_DEF
)(
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  wr_en,
	input  logic [$clog2(PANEL_ROWS)+$clog2(PANEL_COLUMNS):0]     wr_addr,
	input  pixel_t                                                wr_data,
	input  logic                                                  rd_en,
	input  logic [$clog2(PANEL_ROWS)+$clog2(PANEL_COLUMNS):0]     rd_addr_up,
	input  logic [$clog2(PANEL_ROWS)+$clog2(PANEL_COLUMNS):0]     rd_addr_lo,
	output pixel_t                                                rd_data_up,
	output pixel_t                                                rd_data_lo,
	output logic                                                  busy
);
	localparam int ADDR_W = 1 + $clog2(PANEL_ROWS) + $clog2(PANEL_COLUMNS);
	localparam int DEPTH  = 2 ** ADDR_W;

	pixel_t            mem [DEPTH];
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              busy_q;
	pixel_t            clr_data;

	// bank bit is the address MSB: bank 0 takes the reset pixel, bank 1 zero
	assign clr_data = clr_cnt_q[ADDR_W-1] ? '0 : RESET_PIXEL;
	assign busy     = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_cnt_q <= '0;
		end else if (busy_q) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			if (clr_cnt_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_cnt_q] <= clr_data;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_up <= mem[rd_addr_up];
			rd_data_lo <= mem[rd_addr_lo];
		end
	end

endmodule

[hw/rtl/hsd_threshold.sv]
// ----------------------------------------------------------------------------
// hsd_threshold
// PWM threshold accumulator with a decaying step, advanced at frame start.
// ----------------------------------------------------------------------------
module hsd_threshold
	import hsd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_regs_t        cfg_regs,
	input  thr_ctl_t         ctl,
	output logic [THR_W-1:0] thr
);
	localparam int    PROD_W    = STEP_W + PCT_W;
	localparam int    DIV_SHIFT = 30;
	localparam int    RECIP_W   = 24;
	localparam int    MUL_W     = PROD_W + RECIP_W;
	localparam int    QUOT_W    = MUL_W - DIV_SHIFT;
	localparam longint RECIP_VAL = ((longint'(1) << DIV_SHIFT) + PCT_DIV - 1) / PCT_DIV;
	localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(RECIP_VAL);

	logic [STEP_W-1:0] accum_q;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W:0]   sum;
	logic              ovf;
	logic [STEP_W-1:0] accum_nxt;
	logic              dec_vld_s1;
	logic              dec_vld_s2;
	logic [PROD_W-1:0] dec_prod_s1;
	logic [QUOT_W-1:0] dec_quot_s2;
	logic [MUL_W-1:0]  dec_mul;
	logic [STEP_W-1:0] step_sat;

	assign sum       = {1'b0, accum_q} + {1'b0, step_q};
	assign ovf       = sum[STEP_W];
	assign accum_nxt = ovf ? cfg_regs.start_step : sum[STEP_W-1:0];
	assign thr       = ctl.frame_start ? accum_nxt[STEP_W-1 -: THR_W]
	                                   : accum_q[STEP_W-1 -: THR_W];

	// divide by a hundred through the reciprocal, exact for the product range
	assign dec_mul  = MUL_W'(dec_prod_s1) * MUL_W'(DIV_RECIP);
	assign step_sat = dec_quot_s2[QUOT_W-1:STEP_W] != '0 ? '1 : dec_quot_s2[STEP_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q    <= '0;
			step_q     <= START_STEP_RESET;
			dec_vld_s1 <= 1'b0;
			dec_vld_s2 <= 1'b0;
		end else begin
			dec_vld_s1 <= ctl.advance && !ovf;
			dec_vld_s2 <= dec_vld_s1;
			if (ctl.advance) begin
				accum_q <= accum_nxt;
				if (ovf) begin
					step_q <= cfg_regs.start_step;
				end
			end else if (dec_vld_s2) begin
				step_q <= step_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			dec_prod_s1 <= PROD_W'(step_q) * PROD_W'(cfg_regs.decay_percent);
		end
		if (dec_vld_s1) begin
			dec_quot_s2 <= dec_mul[MUL_W-1:DIV_SHIFT];
		end
	end

endmodule

[hw/rtl/hub75_scan_pwm_driver_top.sv]
// ----------------------------------------------------------------------------
// hub75_scan_pwm_driver_top
// HUB75 panel driver: double-buffered frame store written in portrait form,
// 1/N scan with a decaying PWM threshold, one column per scan tick.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload       transfer
//  items     in   in_item_t     write pixel (op write) or scan tick (op tick)
//  results   out  out_item_t    one per scan tick, RGB bits and scan position
//  cfg       in   cfg_write_t   register write, always ready
//
//  One item per cycle while items.ready is high, writes or ticks; the frame
//  store has one write and two read ports: one memory access slot per item.
//  A tick's result reaches the output register by way of the read stage: the
//  transfer edge loads the memory read register, and the compare result moves
//  into the output register when the read stage drains.
//  After reset the frame store runs a clearing pass over all 2*2^(clog2(rows)+
//  clog2(columns)) words (4096 at the default panel) with items.ready low;
//  cfg writes are taken throughout.
//  A stalled result holds in the output register while a new tick moves
//  into the read stage; items.ready drops only once both are full.
//
module hub75_scan_pwm_driver_top
	import hsd_pkg::*;
#(
	parameter int SCAN_ADDRESSES = SCAN_ADDRESSES_DEF,
	parameter int PANEL_COLUMNS  = PANEL_COLUMNS_DEF,
	parameter int PANEL_ROWS     = PANEL_ROWS_DEF
)(
	input logic         clk,
	input logic         arst_n,
	hsd_stream_if.sink   items,
	hsd_stream_if.source results,
	hsd_stream_if.sink   cfg
);
	localparam int ROW_W  = $clog2(PANEL_ROWS);
	localparam int COL_W  = $clog2(PANEL_COLUMNS);
	localparam int SCAN_W = $clog2(SCAN_ADDRESSES);
	localparam int ADDR_W = 1 + ROW_W + COL_W;
	localparam logic [COL_W-1:0]  COL_LAST = COL_W'(PANEL_COLUMNS - 1);
	localparam logic [SCAN_W-1:0] ROW_LAST = SCAN_W'(SCAN_ADDRESSES - 1);

	// Configuration registers
	cfg_regs_t cfg_q;

	// Item decode
	logic items_xfer;
	logic tick_acc;
	logic wr_acc;

	// Scan and bank state
	logic [SCAN_W-1:0] scan_row_q;
	logic [COL_W-1:0]  scan_col_q;
	logic              bank_q;
	logic              swap_pending_q;
	logic              frame_first;
	logic              bank_rd;

	// Write path
	logic [31:0]       x_wide;
	logic [31:0]       y_wide;
	logic [31:0]       land_col;
	logic              wr_in_panel;
	logic [ADDR_W-1:0] wr_addr;
	pixel_t            wr_data;
	logic [CHAN_W-1:0] level;

	// Read path
	logic [31:0]       srow_wide;
	logic [31:0]       scol_wide;
	logic [31:0]       row_up;
	logic [31:0]       row_lo;
	logic [31:0]       rd_col;
	logic              up_ok;
	logic              lo_ok;
	logic [ADDR_W-1:0] rd_addr_up;
	logic [ADDR_W-1:0] rd_addr_lo;
	pixel_t            rd_data_up;
	pixel_t            rd_data_lo;
	logic              store_busy;

	// Threshold
	thr_ctl_t          thr_ctl;
	logic [THR_W-1:0]  thr;

	// Read stage
	logic                   vld_s1;
	logic                   s1_move;
	logic [THR_W-1:0]       thr_s1;
	logic                   up_ok_s1;
	logic                   lo_ok_s1;
	logic [ROW_ADDR_W-1:0]  row_addr_s1;
	logic [SHIFT_COL_W-1:0] shift_col_s1;
	logic                   latch_s1;
	logic                   fs_s1;

	// Output register
	logic      out_vld_q;
	out_item_t out_q;
	out_item_t res_d;
	pixel_t    px_up;
	pixel_t    px_lo;
	logic [2:0] bits_up;
	logic [2:0] bits_lo;

	// ------------------------------------------------------------------
	// Configuration port: always ready; unchecked, the user writes only while idle
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_step    <= START_STEP_RESET;
			cfg_q.decay_percent <= DECAY_RESET;
		end else if (cfg.valid) begin
			case (cfg.data.reg_index)
				CFG_START_STEP: begin
					cfg_q.start_step <= cfg.data.value;
				end
				CFG_DECAY_PERCENT: begin
					cfg_q.decay_percent <= cfg.data.value[PCT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake: the read stage drains into the output register. With the store
	// idle, an item enters when the read stage is free or draining this cycle
	// ------------------------------------------------------------------
	assign s1_move     = vld_s1 && (!out_vld_q || results.ready);
	assign items.ready = !store_busy && (!vld_s1 || s1_move);
	assign items_xfer  = items.valid && items.ready;
	assign tick_acc    = items_xfer && (items.data.op == OP_TICK);
	assign wr_acc      = items_xfer && (items.data.op == OP_WRITE);

	// First column of scan address zero opens a frame; a pending swap takes
	// effect for the reads of that very tick
	assign frame_first = (scan_row_q == '0) && (scan_col_q == '0);
	assign bank_rd     = (frame_first && swap_pending_q) ? ~bank_q : bank_q;

	// ------------------------------------------------------------------
	// Write path: scale by intensity, swap green and blue, rotate into the
	// draw bank (the one not on display)
	// ------------------------------------------------------------------
	always_comb begin
		x_wide      = 32'(items.data.portrait_x);
		y_wide      = 32'(items.data.portrait_y);
		land_col    = 32'(PANEL_COLUMNS - 1) - y_wide;
		wr_in_panel = (x_wide < 32'(PANEL_ROWS)) && (y_wide < 32'(PANEL_COLUMNS));
		wr_addr     = {~bank_q, x_wide[ROW_W-1:0], land_col[COL_W-1:0]};
		level       = items.data.pixel_word[4*CHAN_W-1:3*CHAN_W];
		wr_data     = {scale_channel(items.data.pixel_word[3*CHAN_W-1:2*CHAN_W], level),
		               scale_channel(items.data.pixel_word[CHAN_W-1:0], level),
		               scale_channel(items.data.pixel_word[2*CHAN_W-1:CHAN_W], level)};
	end

	// ------------------------------------------------------------------
	// Read path: upper pixel from row rows-1-addr, lower from scan-1-addr,
	// both at column columns-1-col of the displayed bank
	// ------------------------------------------------------------------
	always_comb begin
		srow_wide  = 32'(scan_row_q);
		scol_wide  = 32'(scan_col_q);
		row_up     = 32'(PANEL_ROWS - 1) - srow_wide;
		row_lo     = 32'(SCAN_ADDRESSES - 1) - srow_wide;
		rd_col     = 32'(PANEL_COLUMNS - 1) - scol_wide;
		up_ok      = srow_wide < 32'(PANEL_ROWS);
		lo_ok      = row_lo < 32'(PANEL_ROWS);
		rd_addr_up = {bank_rd, row_up[ROW_W-1:0], rd_col[COL_W-1:0]};
		rd_addr_lo = {bank_rd, row_lo[ROW_W-1:0], rd_col[COL_W-1:0]};
	end

	hsd_frame_store #(
		.PANEL_ROWS    (PANEL_ROWS),
		.PANEL_COLUMNS (PANEL_COLUMNS)
	) u_frame_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_acc && wr_in_panel),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_en      (tick_acc),
		.rd_addr_up (rd_addr_up),
		.rd_addr_lo (rd_addr_lo),
		.rd_data_up (rd_data_up),
		.rd_data_lo (rd_data_lo),
		.busy       (store_busy)
	);

	// ------------------------------------------------------------------
	// Threshold: advance on the tick that opens a frame
	// ------------------------------------------------------------------
	assign thr_ctl.frame_start = frame_first;
	assign thr_ctl.advance     = tick_acc && frame_first;

	hsd_threshold u_threshold (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_regs (cfg_q),
		.ctl      (thr_ctl),
		.thr      (thr)
	);

	// ------------------------------------------------------------------
	// Scan position, display bank and pending swap
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q     <= '0;
			scan_col_q     <= '0;
			bank_q         <= 1'b0;
			swap_pending_q <= 1'b0;
		end else begin
			if (tick_acc) begin
				if (scan_col_q == COL_LAST) begin
					scan_col_q <= '0;
					scan_row_q <= (scan_row_q == ROW_LAST) ? '0 : scan_row_q + SCAN_W'(1);
				end else begin
					scan_col_q <= scan_col_q + COL_W'(1);
				end
				if (frame_first && swap_pending_q) begin
					bank_q         <= ~bank_q;
					swap_pending_q <= 1'b0;
				end
			end
			// a second request before the frame start is absorbed
			if (wr_acc && items.data.swap_after) begin
				swap_pending_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Read stage: side information travels with the memory read
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (tick_acc) begin
			vld_s1 <= 1'b1;
		end else if (s1_move) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			thr_s1       <= thr;
			up_ok_s1     <= up_ok;
			lo_ok_s1     <= lo_ok;
			row_addr_s1  <= srow_wide[ROW_ADDR_W-1:0];
			shift_col_s1 <= scol_wide[SHIFT_COL_W-1:0];
			latch_s1     <= (scan_col_q == COL_LAST);
			fs_s1        <= frame_first;
		end
	end

	// ------------------------------------------------------------------
	// Compare and output register; rows off the panel read as black
	// ------------------------------------------------------------------
	always_comb begin
		px_up   = up_ok_s1 ? rd_data_up : '0;
		px_lo   = lo_ok_s1 ? rd_data_lo : '0;
		bits_up = pixel_bits(thr_s1, px_up);
		bits_lo = pixel_bits(thr_s1, px_lo);

		res_d.upper_red    = bits_up[2];
		res_d.upper_green  = bits_up[1];
		res_d.upper_blue   = bits_up[0];
		res_d.lower_red    = bits_lo[2];
		res_d.lower_green  = bits_lo[1];
		res_d.lower_blue   = bits_lo[0];
		res_d.row_address  = row_addr_s1;
		res_d.shift_column = shift_col_s1;
		res_d.latch_now    = latch_s1;
		res_d.frame_start  = fs_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_move) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q <= res_d;
		end
	end

	assign results.valid = out_vld_q;
	assign results.data  = out_q;

endmodule

[hw/rtl/hsd_checker.sv]
// ----------------------------------------------------------------------------
// hsd_checker
// Port-level checks on the scan driver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsd_checker
	import hsd_pkg::*;
#(
	parameter int PANEL_COLUMNS = PANEL_COLUMNS_DEF
)(
	input logic          clk,
	input logic          arst_n,
	hsd_stream_if.sink   items,
	hsd_stream_if.source results
);
	localparam int COL_W = $clog2(PANEL_COLUMNS);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(PANEL_COLUMNS - 1);

	logic             tick_xfer;
	logic             res_xfer;
	logic [1:0]       pend_q;
	logic [COL_W-1:0] exp_col_q;
	logic [31:0]      exp_col_wide;
	logic             col_ok;

	assign tick_xfer    = items.valid && items.ready && (items.data.op == OP_TICK);
	assign res_xfer     = results.valid && results.ready;
	assign exp_col_wide = 32'(exp_col_q);
	assign col_ok       = (results.data.shift_column == exp_col_wide[SHIFT_COL_W-1:0])
	                   && (results.data.latch_now == (exp_col_q == COL_LAST));

	// ticks taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (tick_xfer && !res_xfer) begin
			pend_q <= pend_q + 2'd1;
		end else if (!tick_xfer && res_xfer) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	// column of the next delivered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_col_q <= '0;
		end else if (res_xfer) begin
			exp_col_q <= (exp_col_q == COL_LAST) ? '0 : exp_col_q + COL_W'(1);
		end
	end

	`HSD_ASSERT(a_res_valid_held, results.valid && !results.ready |=> results.valid, "result dropped while stalled")
	`HSD_ASSERT(a_res_data_held, results.valid && !results.ready |=> $stable(results.data), "result changed while stalled")
	`HSD_ASSERT(a_res_has_tick, results.valid |-> pend_q != 2'd0, "result without an outstanding tick")
	`HSD_ASSERT(a_col_order, res_xfer |-> col_ok, "shift column or latch out of sequence")
	`HSD_ASSERT_RST(a_res_idle_in_reset, !arst_n |-> !results.valid, "result valid during reset")

endmodule

bind hub75_scan_pwm_driver_top hsd_checker #(
	.PANEL_COLUMNS (PANEL_COLUMNS)
) u_hsd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.items   (items),
	.results (results)
);

[verif/hub75_scan_pwm_driver_top_test.sv]
// ----------------------------------------------------------------------------
// hub75_scan_pwm_driver_top_test
// Self-checking bench for the HUB75 scan and PWM driver. Pixel writes and
// scan ticks go in over the item channel. A behavioural copy of the panel
// tracks both frame banks, the bank swap and the decaying threshold, and
// predicts each column of RGB bits and scan position. Results are checked in
// order against those predictions while both sides stall at random.
// ----------------------------------------------------------------------------
module hub75_scan_pwm_driver_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import hsd_pkg::*;

	localparam int ADDRS          = SCAN_ADDRESSES_DEF;
	localparam int COLS           = PANEL_COLUMNS_DEF;
	localparam int ROWS           = PANEL_ROWS_DEF;
	localparam int BANK           = ROWS * COLS;
	localparam int CLK_HALF_NS    = 6;
	localparam int RESET_CYCLES   = 7;
	localparam int IDLE_PCT       = 9;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_AT_TICKS  = 120;
	localparam int HOLD_CYCLES    = 400;
	localparam int MAX_REPORTS    = 10;
	localparam int RUN_LIMIT_NS   = 5_000_000;

	typedef struct {
		in_item_t item;
		bit       drain_first;   // hold this item back until no result is owed
	} pending_item_t;

	logic clk = 1'b0;
	logic arst_n;

	hsd_stream_if #(.payload_t(in_item_t))   item_bus ();
	hsd_stream_if #(.payload_t(out_item_t))  result_bus ();
	hsd_stream_if #(.payload_t(cfg_write_t)) cfg_bus ();

	hub75_scan_pwm_driver_top #(
		.SCAN_ADDRESSES(ADDRS),
		.PANEL_COLUMNS (COLS),
		.PANEL_ROWS    (ROWS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (item_bus),
		.results(result_bus),
		.cfg    (cfg_bus)
	);

	always #(CLK_HALF_NS) clk = ~clk;

	// ------------------------------------------------------------------
	// Panel model: both banks of the frame store, swap flag, threshold
	// accumulator with its decaying step, scan position and registers.
	// ------------------------------------------------------------------
	pixel_t                 panel_mem [2*BANK];
	logic                   shown_bank;
	logic                   swap_armed;
	logic [16:0]            thr_accum;
	logic [STEP_W-1:0]      thr_step;
	logic [ROW_ADDR_W-1:0]  scan_row_ptr;
	logic [SHIFT_COL_W-1:0] scan_col_ptr;
	logic [STEP_W-1:0]      restart_step;
	logic [PCT_W-1:0]       keep_pct;

	out_item_t     expected_columns [$];
	pending_item_t stim_q [$];
	bit            in_flight   = 1'b0;
	bit            steady_run  = 1'b0;
	int            ticks_taken = 0;
	int            fault_count = 0;
	int            hold_left   = 0;
	bit            hold_done   = 1'b0;

	// Scale one channel by intensity/255, rounding down.
	function automatic logic [CHAN_W-1:0] intensity_scale(
		input logic [CHAN_W-1:0] chan,
		input logic [CHAN_W-1:0] level
	);
		return CHAN_W'((int'(chan) * int'(level)) / 255);
	endfunction

	function automatic string scan_text(input out_item_t s);
		return $sformatf("rgb1=%b%b%b rgb2=%b%b%b addr=%0d col=%0d latch=%b fs=%b",
			s.upper_red, s.upper_green, s.upper_blue,
			s.lower_red, s.lower_green, s.lower_blue,
			s.row_address, s.shift_column, s.latch_now, s.frame_start);
	endfunction

	// Advance the model by one accepted item; a tick queues its column.
	task automatic predict_panel_item(input in_item_t it);
		pixel_t      px, px_up, px_lo;
		logic [7:0]  lvl, thr;
		logic [31:0] next_step;
		int          draw_base, show_base, col;
		bit          fs;
		out_item_t   want;
		if (it.op == OP_WRITE) begin
			// store rotated into the hidden bank, green and blue swapped
			lvl = it.pixel_word[31:24];
			px = {intensity_scale(it.pixel_word[23:16], lvl),
				intensity_scale(it.pixel_word[7:0], lvl),
				intensity_scale(it.pixel_word[15:8], lvl)};
			draw_base = shown_bank ? 0 : BANK;
			panel_mem[draw_base + int'(it.portrait_x) * COLS
				+ (COLS - 1 - int'(it.portrait_y))] = px;
			if (it.swap_after)
				swap_armed = 1'b1;
		end else begin
			fs = (scan_row_ptr == '0) && (scan_col_ptr == '0);
			if (fs) begin
				// swap first, then step the threshold and decay the step
				if (swap_armed) begin
					shown_bank = ~shown_bank;
					swap_armed = 1'b0;
				end
				thr_accum = thr_accum + 17'(thr_step);
				next_step = (32'(thr_step) * 32'(keep_pct)) / PCT_DIV;
				thr_step = (next_step > 32'hFFFF) ? 16'hFFFF : next_step[15:0];
				if (thr_accum > 17'hFFFF) begin
					thr_accum = 17'(restart_step);
					thr_step  = restart_step;
				end
			end
			thr = thr_accum[15:8];
			show_base = shown_bank ? BANK : 0;
			col = COLS - 1 - int'(scan_col_ptr);
			px_up = panel_mem[show_base + (ROWS - 1 - int'(scan_row_ptr)) * COLS + col];
			px_lo = panel_mem[show_base + (ADDRS - 1 - int'(scan_row_ptr)) * COLS + col];
			want.upper_red    = (thr <= px_up[23:16]);
			want.upper_green  = (thr <= px_up[15:8]);
			want.upper_blue   = (thr <= px_up[7:0]);
			want.lower_red    = (thr <= px_lo[23:16]);
			want.lower_green  = (thr <= px_lo[15:8]);
			want.lower_blue   = (thr <= px_lo[7:0]);
			want.row_address  = scan_row_ptr;
			want.shift_column = scan_col_ptr;
			want.latch_now    = (int'(scan_col_ptr) == COLS - 1);
			want.frame_start  = fs;
			expected_columns.push_back(want);
			if (int'(scan_col_ptr) == COLS - 1) begin
				scan_col_ptr = '0;
				scan_row_ptr = (int'(scan_row_ptr) == ADDRS - 1) ? '0
					: scan_row_ptr + ROW_ADDR_W'(1);
			end else begin
				scan_col_ptr = scan_col_ptr + SHIFT_COL_W'(1);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	function automatic in_item_t pixel_write(
		input logic [PORTRAIT_X_W-1:0] x,
		input logic [PORTRAIT_Y_W-1:0] y,
		input logic [PIXEL_WORD_W-1:0] word,
		input logic                    swap
	);
		in_item_t it;
		it.op         = OP_WRITE;
		it.portrait_x = x;
		it.portrait_y = y;
		it.pixel_word = word;
		it.swap_after = swap;
		return it;
	endfunction

	// Mostly ticks; writes carry random content with the intensity pushed to
	// its extremes now and then. A tick's spare fields are random too.
	function automatic in_item_t random_item(input int tick_pct);
		in_item_t it;
		it.op         = ($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_WRITE;
		it.portrait_x = PORTRAIT_X_W'($urandom);
		it.portrait_y = PORTRAIT_Y_W'($urandom);
		it.pixel_word = $urandom;
		case ($urandom_range(0, 7))
			0: it.pixel_word[31:24] = 8'h00;
			1: it.pixel_word[31:24] = 8'hFF;
			2: it.pixel_word[23:0]  = 24'hFF_FFFF;
			default: ;
		endcase
		it.swap_after = ($urandom_range(0, 15) == 0);
		return it;
	endfunction

	task automatic push_item(input in_item_t it);
		pending_item_t p;
		p.item        = it;
		p.drain_first = 1'b0;
		stim_q.push_back(p);
	endtask

	task automatic queue_random(input int count, input int tick_pct);
		repeat (count) push_item(random_item(tick_pct));
	endtask

	// Drive one register transfer and mirror it into the model on acceptance.
	task automatic write_reg(input cfg_index_t idx, input logic [CFG_VALUE_W-1:0] val);
		@(negedge clk);
		cfg_bus.valid = 1'b1;
		cfg_bus.data  = '{reg_index: idx, value: val};
		do @(posedge clk); while (!cfg_bus.ready);
		if (idx == CFG_START_STEP)
			restart_step = val;
		else
			keep_pct = val[PCT_W-1:0];
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// Wait for every queued item and owed result, then let the block idle
	// before the next phase.
	task automatic settle();
		while (stim_q.size() != 0 || in_flight || expected_columns.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Item driver: offer the queue head on the falling edge, hold it until
	// the transfer, idle at random between items.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
		end else if (!in_flight) begin
			if (stim_q.size() != 0 && (steady_run || $urandom_range(0, 99) >= IDLE_PCT)
					&& !(stim_q[0].drain_first && expected_columns.size() != 0)) begin
				item_bus.valid <= 1'b1;
				item_bus.data  <= stim_q[0].item;
				in_flight = 1'b1;
			end else begin
				item_bus.valid <= 1'b0;
			end
		end
	end

	// Item monitor: each transfer advances the model and retires the head.
	always @(posedge clk) begin
		if (arst_n && item_bus.valid && item_bus.ready) begin
			predict_panel_item(item_bus.data);
			void'(stim_q.pop_front());
			in_flight = 1'b0;
			if (item_bus.data.op == OP_TICK)
				ticks_taken++;
		end
	end

	// Result back-pressure: random stalls, plus one long hold-off so the
	// pipeline fills and the item channel stalls behind it.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			result_bus.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && ticks_taken >= HOLD_AT_TICKS) begin
			result_bus.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			result_bus.ready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Result checker: compare each transfer with the oldest prediction.
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (expected_columns.size() == 0) begin
				if (fault_count < MAX_REPORTS)
					$display("%0t: result with none owed: got %s",
						$time, scan_text(result_bus.data));
				fault_count++;
			end else begin
				want = expected_columns.pop_front();
				if (result_bus.data !== want) begin
					if (fault_count < MAX_REPORTS)
						$display("%0t: column mismatch: expected %s, got %s",
							$time, scan_text(want), scan_text(result_bus.data));
					fault_count++;
				end
			end
		end
	end

	// Hard stop in case the block wedges.
	initial begin
		#(RUN_LIMIT_NS);
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sequence: reset, directed items, random phases, the first at reset values,
	// later ones under fresh register settings written while the block is idle.
	// ------------------------------------------------------------------
	initial begin
		arst_n           = 1'b0;
		item_bus.valid   = 1'b0;
		item_bus.data    = '0;
		result_bus.ready = 1'b0;
		cfg_bus.valid    = 1'b0;
		cfg_bus.data     = '0;

		// power-on contents: grey frame on show, blank frame hidden
		for (int i = 0; i < BANK; i++) begin
			panel_mem[i]        = RESET_PIXEL;
			panel_mem[BANK + i] = '0;
		end
		shown_bank   = 1'b0;
		swap_armed   = 1'b0;
		thr_accum    = '0;
		restart_step = START_STEP_RESET;
		keep_pct     = DECAY_RESET;
		thr_step     = START_STEP_RESET;
		scan_row_ptr = '0;
		scan_col_ptr = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: corners of the portrait frame and intensity extremes.
		// Column 0 of portrait rows 31 and 15 lands on the first tick read, so the
		// green/blue swap and zero intensity show up straight away.
		push_item(pixel_write(5'd0,  6'd0,  32'hFFFF_FFFF, 1'b0));
		push_item(pixel_write(5'd31, 6'd63, 32'hFF00_0000, 1'b0));
		push_item(pixel_write(5'd31, 6'd0,  32'h00FF_FFFF, 1'b0));
		push_item(pixel_write(5'd0,  6'd63, 32'h80FF_00FF, 1'b0));
		push_item(pixel_write(5'd15, 6'd0,  32'hFF12_3456, 1'b0));
		// swap request, then a second one that must be absorbed
		push_item(pixel_write(5'd16, 6'd1,  32'h7FAB_CDEF, 1'b1));
		push_item(pixel_write(5'd31, 6'd1,  32'hFF01_8000, 1'b1));
		// first tick is the frame start: swap applies, threshold steps
		repeat (12) push_item(random_item(100));

		// Reset register values, random traffic.
		queue_random(100, 85);
		settle();

		// Largest restart step with no decay. Pause the sender once
		// mid-phase until every owed result is in.
		write_reg(CFG_START_STEP, 16'hFFFF);
		write_reg(CFG_DECAY_PERCENT, 16'd100);
		queue_random(100, 85);
		stim_q[50].drain_first = 1'b1;
		settle();

		// Smallest restart step, step decays to nothing; no idling here.
		write_reg(CFG_START_STEP, 16'd1);
		write_reg(CFG_DECAY_PERCENT, 16'd0);
		steady_run = 1'b1;
		queue_random(100, 85);
		settle();
		steady_run = 1'b0;

		// Decay above one hundred.
		write_reg(CFG_START_STEP, CFG_VALUE_W'($urandom_range(1, 16'hFFFF)));
		write_reg(CFG_DECAY_PERCENT, 16'd127);
		queue_random(60, 85);
		settle();

		// Zero restart step.
		write_reg(CFG_START_STEP, 16'd0);
		write_reg(CFG_DECAY_PERCENT, CFG_VALUE_W'($urandom_range(0, PCT_DIV)));
		queue_random(50, 85);
		settle();

		// Random in-range setting to finish.
		write_reg(CFG_START_STEP, CFG_VALUE_W'($urandom_range(1, 16'hFFFF)));
		write_reg(CFG_DECAY_PERCENT, CFG_VALUE_W'($urandom_range(1, PCT_DIV)));
		queue_random(70, 90);
		settle();

		if (fault_count == 0 && expected_columns.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/hsd_pkg.sv
hw/rtl/hsd_stream_if.sv
hw/rtl/hsd_frame_store.sv
hw/rtl/hsd_threshold.sv
hw/rtl/hub75_scan_pwm_driver_top.sv
hw/rtl/hsd_checker.sv
verif/hub75_scan_pwm_driver_top_test.sv
